// File: design/ahfd_pkg.sv
// Shared types, constants and helper functions of the ASCII hex frame decoder.
// No dependencies; every other design file refers to this package by scoped names.
package ahfd_pkg;

    // Number of device ID characters in a frame (1 to 8).
    localparam int IdLen = 8;
    localparam int IdxW = (IdLen > 1) ? $clog2(IdLen) : 1;
    localparam int PosW = 17;
    localparam logic [PosW-1:0] PosMax = '1;
    localparam int RegIndexW = 2;

    // Frame landmarks derived from the ID length.
    localparam logic [15:0] MinLen = 16'(2 + IdLen);
    localparam logic [PosW-1:0] IdEnd = PosW'(5 + IdLen);
    localparam logic [PosW-1:0] CmdLast = PosW'(6 + IdLen);
    localparam logic [PosW-1:0] CmdEnd = PosW'(7 + IdLen);

    localparam logic [15:0] CrcPoly = 16'h1021;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ERROR = 2'd1,
        STATUS_CRC   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_CONTENT = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [RegIndexW-1:0] {
        REG_START_FLAG    = 2'd0,
        REG_END_FLAG      = 2'd1,
        REG_DEVICE_ID     = 2'd2,
        REG_COMMAND_LIMIT = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  start_flag;
        logic [7:0]  end_flag;
        logic [63:0] device_id;
        logic [8:0]  command_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  content_byte;
        status_t     status;
        logic [7:0]  command;
        logic [15:0] content_length;
    } result_t;

    // Handshake between the input register, the parser and the output register.
    typedef struct packed {
        logic  item_valid;
        logic  take;
    } flow_t;

    // CRC-16/XMODEM update by one byte, most significant bit first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CrcPoly;
            end
        end
        return c;
    endfunction

    function automatic logic hex_valid(input logic [7:0] c);
        return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "F"))
            || ((c >= "a") && (c <= "f"));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        if ((c >= "0") && (c <= "9"))
        begin
            t = c - 8'h30;
        end
        else if ((c >= "A") && (c <= "F"))
        begin
            t = c - 8'h37;
        end
        else
        begin
            t = c - 8'h57;
        end
        return t[3:0];
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    // Characters match when equal or when both are letters differing only in case.
    function automatic logic id_char_ok(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] a9;
        logic [8:0] b9;
        a9 = {1'b0, a};
        b9 = {1'b0, b};
        return (a == b) || (is_letter(a) && is_letter(b)
            && (((a9 + 9'd32) == b9) || ((b9 + 9'd32) == a9)));
    endfunction

endpackage

// File: design/ahfd_if.sv
// Channel interfaces of the ASCII hex frame decoder: input bytes, results and
// configuration writes. Depends on ahfd_pkg for the register index width.
interface ahfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ahfd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  content_byte;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [15:0] content_length;

    modport source (output valid, output kind, output content_byte, output status,
                    output command, output content_length, input ready);
    modport sink (input valid, input kind, input content_byte, input status,
                  input command, input content_length, output ready);
endinterface

interface ahfd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ahfd_pkg::RegIndexW-1:0] index;
    logic [63:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/ahfd_cfg_regs.sv
// Configuration register file of the ASCII hex frame decoder.
// Depends on ahfd_pkg and the ahfd_cfg_if interface.
module ahfd_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    ahfd_cfg_if.sink          cfg,
    output ahfd_pkg::cfg_t    regs
);

    ahfd_pkg::cfg_t regs_reg;
    ahfd_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (ahfd_pkg::reg_index_t'(cfg.index))
                ahfd_pkg::REG_START_FLAG:    regs_next.start_flag = cfg.data[7:0];
                ahfd_pkg::REG_END_FLAG:      regs_next.end_flag = cfg.data[7:0];
                ahfd_pkg::REG_DEVICE_ID:     regs_next.device_id = cfg.data;
                ahfd_pkg::REG_COMMAND_LIMIT: regs_next.command_limit = cfg.data[8:0];
                default:                     regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_flag <= 8'd0;
            regs_reg.end_flag <= 8'd0;
            regs_reg.device_id <= 64'd0;
            regs_reg.command_limit <= 9'd256;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// File: design/ahfd_in_stage.sv
// Input register of the ASCII hex frame decoder: holds one accepted byte until
// the parser consumes it. Depends on ahfd_pkg and the ahfd_byte_if interface.
module ahfd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    ahfd_byte_if.sink         frame,
    input  logic              take,
    output logic              item_valid,
    output ahfd_pkg::item_t   item
);

    logic            valid_reg;
    logic            valid_next;
    ahfd_pkg::item_t item_reg;
    logic            consume;
    logic            accept;

    // The register frees up in the same cycle the parser consumes it.
    assign consume = valid_reg && take;
    assign frame.ready = !valid_reg || consume;
    assign accept = frame.valid && frame.ready;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= {frame.data_byte, frame.last_byte};
        end
    end

endmodule

// File: design/ahfd_parser.sv
// Frame parser of the ASCII hex frame decoder: per-frame state, running CRC and
// the decode of one byte per cycle unless the output stalls. Depends on ahfd_pkg.
module ahfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  ahfd_pkg::cfg_t    regs,
    input  ahfd_pkg::flow_t   flow,
    input  ahfd_pkg::item_t   item,
    output logic              res_valid,
    output ahfd_pkg::result_t res
);

    logic [ahfd_pkg::PosW-1:0] pos_reg, pos_next;
    logic [15:0]               crc_reg, crc_next;
    logic [15:0]               len_reg, len_next;
    logic [7:0]                cmd_reg, cmd_next;
    logic [15:0]               rcrc_reg, rcrc_next;
    logic                      fe_reg, fe_next;
    logic                      idm_reg, idm_next;
    logic                      cc_reg, cc_next;

    logic                      fire;
    logic [7:0]                b;
    logic                      hexv;
    logic [3:0]                hexd;
    logic [15:0]               crc_upd;
    logic [15:0]               len_shift;
    logic [7:0]                cmd_shift;
    logic [15:0]               clen;
    logic [ahfd_pkg::PosW-1:0] len_ext;
    logic [ahfd_pkg::PosW-1:0] end_data;
    logic [ahfd_pkg::PosW-1:0] end_crc;
    logic [ahfd_pkg::PosW-1:0] id_off;
    logic [ahfd_pkg::IdxW-1:0] id_shift;
    logic [7:0]                want;

    assign fire = flow.item_valid && flow.take;
    assign b = item.data_byte;
    assign hexv = ahfd_pkg::hex_valid(b);
    assign hexd = ahfd_pkg::hex_value(b);
    assign crc_upd = ahfd_pkg::crc16_byte(crc_reg, b);
    assign len_shift = {len_reg[11:0], hexd};
    assign cmd_shift = {cmd_reg[3:0], (hexv ? hexd : 4'd0)};
    assign clen = (len_reg < ahfd_pkg::MinLen) ? 16'd0 : (len_reg - ahfd_pkg::MinLen);
    assign len_ext = {1'b0, len_reg};
    assign end_data = len_ext + 17'd4;
    assign end_crc = len_ext + 17'd8;

    // The first ID character sits in the highest used byte of the register.
    assign id_off = pos_reg - 17'd5;
    assign id_shift = ahfd_pkg::IdxW'(ahfd_pkg::IdLen - 1) - id_off[ahfd_pkg::IdxW-1:0];
    assign want = regs.device_id[8 * id_shift +: 8];

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        rcrc_next = rcrc_reg;
        fe_next = fe_reg;
        idm_next = idm_reg;
        cc_next = cc_reg;
        res_valid = 1'b0;
        res.kind = ahfd_pkg::KIND_CONTENT;
        res.content_byte = 8'd0;
        res.status = ahfd_pkg::STATUS_OK;
        res.command = cmd_reg;
        res.content_length = clen;

        if (item.last_byte)
        begin
            res_valid = 1'b1;
            res.kind = ahfd_pkg::KIND_STATUS;
            if (fe_reg || !cc_reg || (b != regs.end_flag))
            begin
                res.status = ahfd_pkg::STATUS_ERROR;
            end
            else if (crc_reg != rcrc_reg)
            begin
                res.status = ahfd_pkg::STATUS_CRC;
            end
            else if (idm_reg)
            begin
                res.status = ahfd_pkg::STATUS_ERROR;
            end
            pos_next = '0;
            crc_next = 16'd0;
            len_next = 16'd0;
            cmd_next = 8'd0;
            rcrc_next = 16'd0;
            fe_next = 1'b0;
            idm_next = 1'b0;
            cc_next = 1'b0;
        end
        else
        begin
            if (pos_reg != ahfd_pkg::PosMax)
            begin
                pos_next = pos_reg + 17'd1;
            end
            if (!fe_reg)
            begin
                if (pos_reg == 17'd0)
                begin
                    fe_next = (b != regs.start_flag);
                    crc_next = crc_upd;
                end
                else if (pos_reg <= 17'd4)
                begin
                    crc_next = crc_upd;
                    if (!hexv)
                    begin
                        fe_next = 1'b1;
                        len_next = 16'd0;
                    end
                    else
                    begin
                        len_next = len_shift;
                        if ((pos_reg == 17'd4) && (len_shift < ahfd_pkg::MinLen))
                        begin
                            fe_next = 1'b1;
                        end
                    end
                end
                else if (pos_reg <= end_data)
                begin
                    crc_next = crc_upd;
                    if (pos_reg < ahfd_pkg::IdEnd)
                    begin
                        if (!ahfd_pkg::id_char_ok(want, b))
                        begin
                            idm_next = 1'b1;
                        end
                    end
                    else if (pos_reg < ahfd_pkg::CmdEnd)
                    begin
                        cmd_next = cmd_shift;
                        // A bad digit or a command at or above the limit rejects it.
                        if (!hexv || ((pos_reg == ahfd_pkg::CmdLast)
                            && ({1'b0, cmd_shift} >= regs.command_limit)))
                        begin
                            idm_next = 1'b1;
                        end
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.content_byte = b;
                    end
                end
                else if (pos_reg <= end_crc)
                begin
                    if (!hexv)
                    begin
                        fe_next = 1'b1;
                    end
                    else
                    begin
                        rcrc_next = {rcrc_reg[11:0], hexd};
                        if (pos_reg == end_crc)
                        begin
                            cc_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= 16'd0;
            len_reg <= 16'd0;
            cmd_reg <= 8'd0;
            rcrc_reg <= 16'd0;
            fe_reg <= 1'b0;
            idm_reg <= 1'b0;
            cc_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            rcrc_reg <= rcrc_next;
            fe_reg <= fe_next;
            idm_reg <= idm_next;
            cc_reg <= cc_next;
        end
    end

endmodule

// File: design/ahfd_out_stage.sv
// Output register of the ASCII hex frame decoder: holds one result request until
// the sink takes it. Depends on ahfd_pkg and the ahfd_result_if interface.
module ahfd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              res_valid,
    input  ahfd_pkg::result_t res,
    output logic              take,
    ahfd_result_if.source     result
);

    logic              valid_reg;
    logic              valid_next;
    ahfd_pkg::result_t res_reg;
    logic              load;

    // The register can take a new entry when empty or being emptied this cycle.
    assign take = !valid_reg || result.ready;
    assign load = take && item_valid && res_valid;

    assign result.valid = valid_reg;
    assign result.kind = res_reg.kind;
    assign result.content_byte = res_reg.content_byte;
    assign result.status = res_reg.status;
    assign result.command = res_reg.command;
    assign result.content_length = res_reg.content_length;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = item_valid && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: design/ascii_hex_frame_decoder_top.sv
// ASCII hex frame decoder, top level. The parser decodes each byte from the input
// register and any result request goes to the output register. Throughput: one
// byte per cycle unless the sink stalls, set by the combinational parser and CRC.
// Reset (rst_n, asynchronous, active low) clears the frame state, empties both
// pipeline registers and loads the configuration defaults (command limit 256).
// Depends on ahfd_pkg, the interfaces in ahfd_if and the ahfd_* submodules.
module ascii_hex_frame_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    ahfd_byte_if.sink     frame,
    ahfd_result_if.source result,
    ahfd_cfg_if.sink      cfg
);

    // Configuration registers. Writes are expected only while the decoder is
    // idle, so they take effect immediately without any shadowing.
    ahfd_pkg::cfg_t    regs;

    // Pipeline handshake and the data moving between the stages.
    ahfd_pkg::flow_t   flow;
    ahfd_pkg::item_t   item;
    logic              item_valid;
    logic              take;
    logic              res_valid;
    ahfd_pkg::result_t res;

    assign flow.item_valid = item_valid;
    assign flow.take = take;

    ahfd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // The input register decouples the byte source from the parser. It reloads
    // in the same cycle its byte moves on, so back-to-back bytes flow freely.
    ahfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The parser advances the frame state on every byte it consumes. Header,
    // ID, command and CRC digits produce nothing; content bytes produce a
    // content request, and the last byte of a buffer produces the status
    // request and clears the frame state for the next buffer.
    ahfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .flow      (flow),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // The output register holds a finished request while the sink stalls. The
    // parser only advances when this register is free or being emptied.
    ahfd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res        (res),
        .take       (take),
        .result     (result)
    );

    // A content request always carries an OK status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == ahfd_pkg::KIND_CONTENT))
            |-> (result.status == ahfd_pkg::STATUS_OK))
        else $error("content request with nonzero status");

    // A status request never carries a content byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == ahfd_pkg::KIND_STATUS))
            |-> (result.content_byte == 8'd0))
        else $error("status request with nonzero content byte");

    // The status code is never the unused encoding.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status != 2'd3))
        else $error("invalid status code");

    // A byte that ends a buffer must reach the output on the following cycle
    // whenever the output register was free to take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.last_byte && take) |=> (result.valid
            && (result.kind == ahfd_pkg::KIND_STATUS)))
        else $error("last byte did not produce a status request");

endmodule
